### src/pts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package pts_pkg;

    // Slot table size and derived widths
    localparam int TASK_SLOTS  = 8;
    localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int ID_W        = 3;
    localparam int KIND_W      = 3;
    localparam int PERIOD_W    = 16;
    localparam int DELAY_W     = 8;
    localparam int MASK_W      = 8;
    localparam int FIRE_W      = (TASK_SLOTS > MASK_W) ? TASK_SLOTS : MASK_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kind codes as they arrive on the port
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

    // Decoded operation carried to the back end
    typedef enum logic [2:0] {
        OP_TICK,
        OP_CREATE,
        OP_SUSPEND,
        OP_RESUME,
        OP_DELETE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period;
        logic [DELAY_W-1:0]  first_delay;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic              slot_suspended;
        logic              slot_present;
    } result_t;

    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic [DELAY_W-1:0]  first_delay;
    } cmd_t;

endpackage

`default_nettype wire

### src/pts_front.sv
// Front end: takes item beats and decodes them into back-end commands.
// Depends on pts_pkg.
`default_nettype none

module pts_front
    import pts_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire logic  queue_full,
    output logic       push,
    output cmd_t       cmd
);

    logic in_range;

    // Back-pressure comes straight from the queue fill state
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    assign in_range = int'(item.task_id) < TASK_SLOTS;

    // Classify: out-of-range slot accesses and unknown kinds become queries
    always_comb
    begin
        cmd.in_range    = in_range;
        cmd.slot        = SLOT_W'(item.task_id);
        cmd.period      = item.period;
        cmd.first_delay = item.first_delay;
        if (item.kind == KIND_TICK)
        begin
            cmd.op = OP_TICK;
        end
        else if (!in_range)
        begin
            cmd.op = OP_QUERY;
        end
        else
        begin
            unique case (item.kind)
                KIND_CREATE:  cmd.op = OP_CREATE;
                KIND_SUSPEND: cmd.op = OP_SUSPEND;
                KIND_RESUME:  cmd.op = OP_RESUME;
                KIND_DELETE:  cmd.op = OP_DELETE;
                default:      cmd.op = OP_QUERY;
            endcase
        end
    end

    // A beat is never pushed into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("front pushed into a full queue");

endmodule

`default_nettype wire

### src/pts_queue.sv
// Short command queue decoupling the front end from the back end.
// Depends on pts_pkg.
`default_nettype none

module pts_queue
    import pts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_DEPTH)
        else $error("queue fill count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> head_valid)
        else $error("queue empty after a push");

endmodule

`default_nettype wire

### src/pts_back.sv
// Back end: slot table, tick engine and result register.
// Depends on pts_pkg.
`default_nettype none

module pts_back
    import pts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output result_t   result,
    output logic      result_valid,
    input  wire logic result_stall
);

    localparam int LAST = TASK_SLOTS - 1;

    logic                valid_reg  [TASK_SLOTS];
    logic                valid_next [TASK_SLOTS];
    logic                held_reg   [TASK_SLOTS];
    logic                held_next  [TASK_SLOTS];
    logic [PERIOD_W-1:0] period_reg [TASK_SLOTS];
    logic [PERIOD_W-1:0] period_next[TASK_SLOTS];
    logic [PERIOD_W-1:0] count_reg  [TASK_SLOTS];
    logic [PERIOD_W-1:0] count_next [TASK_SLOTS];
    logic [FIRE_W-1:0]   fire;
    result_t             result_reg, result_next;
    logic                result_valid_reg;
    logic                load;

    // Take a command whenever the result register is free or being emptied
    assign load         = head_valid && (!result_valid_reg || !result_stall);
    assign pop          = load;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Next table state for the command at the queue head
    always_comb
    begin
        fire = '0;
        for (int s = 0; s < TASK_SLOTS; s++)
        begin
            valid_next[s]  = valid_reg[s];
            held_next[s]   = held_reg[s];
            period_next[s] = period_reg[s];
            count_next[s]  = count_reg[s];
            case (head_cmd.op)
                OP_TICK:
                begin
                    if (valid_reg[s] && !held_reg[s])
                    begin
                        if (count_reg[s] == '0)
                        begin
                            fire[s] = 1'b1;
                            // zero period counts as one
                            count_next[s] = (period_reg[s] == '0) ? '0
                                                                  : period_reg[s] - 1'b1;
                        end
                        else
                        begin
                            count_next[s] = count_reg[s] - 1'b1;
                        end
                    end
                end
                OP_CREATE:
                begin
                    if (SLOT_W'(s) == head_cmd.slot)
                    begin
                        valid_next[s]  = 1'b1;
                        held_next[s]   = 1'b0;
                        period_next[s] = head_cmd.period;
                        count_next[s]  = PERIOD_W'(head_cmd.first_delay);
                    end
                end
                OP_SUSPEND:
                begin
                    if (SLOT_W'(s) == head_cmd.slot)
                    begin
                        held_next[s] = 1'b1;
                    end
                end
                OP_RESUME:
                begin
                    if (SLOT_W'(s) == head_cmd.slot)
                    begin
                        held_next[s] = 1'b0;
                    end
                end
                OP_DELETE:
                begin
                    // slots at and above the deleted one take their upper neighbour; the last slot empties
                    if (SLOT_W'(s) >= head_cmd.slot)
                    begin
                        if (s == LAST)
                        begin
                            valid_next[s]  = 1'b0;
                            held_next[s]   = 1'b0;
                            period_next[s] = '0;
                            count_next[s]  = '0;
                        end
                        else
                        begin
                            valid_next[s]  = valid_reg[(s == LAST) ? s : s + 1];
                            held_next[s]   = held_reg[(s == LAST) ? s : s + 1];
                            period_next[s] = period_reg[(s == LAST) ? s : s + 1];
                            count_next[s]  = count_reg[(s == LAST) ? s : s + 1];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result: fire mask of this beat and the addressed slot after it
    always_comb
    begin
        result_next.fired_mask     = fire[MASK_W-1:0];
        result_next.slot_suspended = head_cmd.in_range ? held_next[head_cmd.slot] : 1'b0;
        result_next.slot_present   = head_cmd.in_range ? valid_next[head_cmd.slot] : 1'b0;
    end

    // Table state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TASK_SLOTS; s++)
            begin
                valid_reg[s]  <= 1'b0;
                held_reg[s]   <= 1'b0;
                period_reg[s] <= '0;
                count_reg[s]  <= '0;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                for (int s = 0; s < TASK_SLOTS; s++)
                begin
                    valid_reg[s]  <= valid_next[s];
                    held_reg[s]   <= held_next[s];
                    period_reg[s] <= period_next[s];
                    count_reg[s]  <= count_next[s];
                end
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    a_mask_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        load && head_cmd.op != OP_TICK |=> result_reg.fired_mask == '0)
        else $error("fire mask set on a non-tick beat");

    a_delete_empties_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && head_cmd.op == OP_DELETE |=> !valid_reg[LAST] && !held_reg[LAST])
        else $error("last slot not emptied by delete");

    a_out_of_range_blank: assert property (@(posedge clk) disable iff (!rst_n)
        load && !head_cmd.in_range
        |=> !result_reg.slot_present && !result_reg.slot_suspended)
        else $error("out-of-range slot reported as present");

endmodule

`default_nettype wire

### src/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler, top level: front decoder, command queue, back end.
// Path: an item beat is written into the command queue, then its result into the result register.
// Throughput: one item per cycle sustained while result_stall is low; the slot table updates once per command.
// Back-pressure: the front stalls only when the two-entry command queue is full.
// Reset: asynchronous, active low; the slot table empties and queue and result_valid clear.
// Depends on pts_pkg, pts_front, pts_queue, pts_back.
`default_nettype none

module periodic_task_tick_scheduler
    import pts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire logic    item_valid,
    output logic         item_stall,
    output result_t      result,
    output logic         result_valid,
    input  wire logic    result_stall
);

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    pts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire
